// ----- src/lwpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpq_pkg
// Shared sizes, entry layout and status codes for the lock wait queue.
// ----------------------------------------------------------------------------
package lwpq_pkg;
	localparam int LOCK_COUNT  = 16;
	localparam int QUEUE_DEPTH = 16;
	localparam int PROC_COUNT  = 64;
	localparam int LOCK_W = 4;
	localparam int PID_W  = 6;
	localparam int PRIO_W = 8;
	localparam int ENTRY_W = PRIO_W + 1 + PID_W;
	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int LSEL_W = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_NOMATCH = 2'd2;

	typedef logic [ENTRY_W-1:0] entry_t;

	// Command broadcast to every cell for one update cycle.
	typedef struct packed {
		logic              ins;     // insert this cycle
		logic              rem;     // remove this cycle
		logic [LSEL_W-1:0] lock;
		entry_t            word;
	} cell_cmd_t;
endpackage

// ----- src/lwpq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwpq_cell
// One queue slot for every lock: holds an entry per lock, compares against
// the request and takes its neighbor's entry on an insert or remove shift.
// ----------------------------------------------------------------------------
module lwpq_cell import lwpq_pkg::*; (
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  logic      cnt_gt,     // slot index below the addressed count
	input  logic      at_tail,    // slot index equals the addressed count
	input  logic      ins_here_in, // a lower slot already chose insertion
	input  logic      rem_here_in, // a lower slot already matched
	input  entry_t    prev_entry, // entry of slot index - 1
	input  entry_t    next_entry, // entry of slot index + 1
	output logic      ins_here_out,
	output logic      rem_here_out,
	output logic      ins_mark,   // this slot is the insert point
	output logic      rem_mark,   // this slot is the removed one
	output entry_t    entry
);
	entry_t mem_q [LOCK_COUNT];
	logic ins_cond, rem_cond;

	assign entry    = mem_q[cmd.lock];
	// The first free slot is the insert point when no stored entry is lower.
	assign ins_cond = (cnt_gt && (entry[ENTRY_W-1 -: PRIO_W] < cmd.word[ENTRY_W-1 -: PRIO_W]))
		|| at_tail;
	assign rem_cond = cnt_gt && (entry == cmd.word);
	assign ins_mark = ins_cond && !ins_here_in;
	assign rem_mark = rem_cond && !rem_here_in;
	assign ins_here_out = ins_here_in || ins_cond;
	assign rem_here_out = rem_here_in || rem_cond;

	// Shift down on insert at or above the insert point, up on remove past it.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (ins_mark) mem_q[cmd.lock] <= cmd.word;
			else if (ins_here_in) mem_q[cmd.lock] <= prev_entry;
		end else if (cmd.rem && (rem_here_in || rem_mark)) begin
			mem_q[cmd.lock] <= next_entry;
		end
	end
endmodule

// ----- src/lock_wait_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_wait_priority_queue
// Per-lock wait queues in descending priority, with insert and remove-by-key.
// ----------------------------------------------------------------------------
// The request is registered at the input transfer; in the next cycle the row
// of QUEUE_DEPTH slot cells compares all entries of the addressed lock in
// parallel and shifts them one place while the result is registered, and the
// result then sits in the output register until taken. The next request is
// taken only when no request is in progress and the result register is free
// or being drained, so a new request is never taken before the last one's
// result is registered, and receiver stalls hold off input. Insert places the
// entry before the first one of strictly lower priority; remove drops the
// first exact match. Status gives the outcome and position the slot used
// (0 on error).
// ----------------------------------------------------------------------------
module lock_wait_priority_queue import lwpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata, // lock_id[3:0], priority_req[11:4], access_kind[12],
	                             // proc_id[18:13], zero fill
	input  logic        s_tuser, // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata  // status[1:0], position[5:2], zero fill
);
	logic              busy_q, rtype_q, bad_q;
	logic [LSEL_W-1:0] lock_q;
	entry_t            word_q;
	logic [CNT_W-1:0]  cnt_q [LOCK_COUNT];
	logic [1:0]        status_q;
	logic [3:0]        pos_q;
	logic              ovalid_q;

	logic [CNT_W-1:0]  cnt;
	logic              full;
	cell_cmd_t         cmd;
	logic [QUEUE_DEPTH:0] ins_chain, rem_chain;
	logic [QUEUE_DEPTH-1:0] ins_mark, rem_mark;
	entry_t            ent [QUEUE_DEPTH];
	logic [SLOT_W-1:0] ins_pos, rem_pos;
	logic              found;

	assign s_tready = !busy_q && (!ovalid_q || m_tready);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {2'b00, pos_q, status_q};

	assign cnt  = cnt_q[lock_q];
	assign full = (cnt == CNT_W'(QUEUE_DEPTH));
	assign found = rem_chain[QUEUE_DEPTH];
	assign cmd.lock = lock_q;
	assign cmd.word = word_q;
	assign cmd.ins  = busy_q && !bad_q && !rtype_q && !full;
	assign cmd.rem  = busy_q && !bad_q && rtype_q && found;

	assign ins_chain[0] = 1'b0;
	assign rem_chain[0] = 1'b0;

	genvar g;
	generate
		for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			lwpq_cell u_cell (
				.clk(clk), .cmd(cmd),
				.cnt_gt(CNT_W'(g) < cnt),
				.at_tail(CNT_W'(g) == cnt),
				.ins_here_in(ins_chain[g]), .rem_here_in(rem_chain[g]),
				.prev_entry(ent[(g == 0) ? 0 : g-1]),
				.next_entry(ent[(g == QUEUE_DEPTH-1) ? g : g+1]),
				.ins_here_out(ins_chain[g+1]), .rem_here_out(rem_chain[g+1]),
				.ins_mark(ins_mark[g]), .rem_mark(rem_mark[g]),
				.entry(ent[g])
			);
		end
	endgenerate

	// Encode the one-hot marks; no insert mark means append at the count.
	always_comb begin
		ins_pos = cnt[SLOT_W-1:0];
		rem_pos = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (ins_mark[i]) ins_pos = SLOT_W'(i);
			if (rem_mark[i]) rem_pos = SLOT_W'(i);
		end
	end

	// Track busy and output-valid state and update the per-lock count when applied.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < LOCK_COUNT; i++) cnt_q[i] <= '0;
		end else begin
			if (ovalid_q && m_tready) ovalid_q <= 1'b0;
			if (s_tvalid && s_tready) busy_q <= 1'b1;
			if (busy_q) begin
				busy_q   <= 1'b0;
				ovalid_q <= 1'b1;
				if (cmd.ins) cnt_q[lock_q] <= cnt + 1'b1;
				if (cmd.rem) cnt_q[lock_q] <= cnt - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rtype_q <= s_tuser;
			lock_q  <= LSEL_W'(s_tdata[3:0]);
			word_q  <= {s_tdata[11:4], s_tdata[12], s_tdata[18:13]};
			bad_q   <= (32'(s_tdata[3:0]) >= LOCK_COUNT) || (32'(s_tdata[18:13]) >= PROC_COUNT);
		end
		if (busy_q) begin
			if (bad_q) begin
				status_q <= rtype_q ? ST_NOMATCH : ST_FULL;
				pos_q    <= '0;
			end else if (!rtype_q) begin
				status_q <= full ? ST_FULL : ST_OK;
				pos_q    <= full ? 4'd0 : 4'(ins_pos);
			end else begin
				status_q <= found ? ST_OK : ST_NOMATCH;
				pos_q    <= found ? 4'(rem_pos) : 4'd0;
			end
		end
	end
endmodule

// ----- bench/lock_wait_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lock_wait_priority_queue_tb
// Stream bench for the per-lock priority wait queues.
// ----------------------------------------------------------------------------
// Directed rows cover reset state, missed and head/tail removes, priority
// extremes and, by filling lock 7, a full queue. Random traffic follows:
// mostly inserts and removes of entries known to be queued, in stretches on
// a few locks so the queues fill, plus noise removes. Every result is
// checked against a local shadow of the queues. The sender bursts, the
// receiver stalls, and once it holds off for a long stretch so input backs up.
// ----------------------------------------------------------------------------
module lock_wait_priority_queue_tb;
	import lwpq_pkg::*;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;
	localparam int   RANDOM_ITEMS = 1800;

	typedef struct {
		logic       req;
		logic [3:0] lock;
		logic [7:0] prio;
		logic       kind;
		logic [5:0] pid;
		logic       typed;     // expected result typed in below
		logic [1:0] st;
		logic [3:0] pos;
	} stim_row_t;

	typedef struct {
		logic [1:0] st;
		logic [3:0] pos;
	} queue_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;

	// Shadow of the queues, for prediction.
	entry_t      shadow_q [LOCK_COUNT][QUEUE_DEPTH];
	int          shadow_cnt [LOCK_COUNT];
	queue_result_t pending_results [$];
	int          error_count = 0;
	bit          long_hold = 1'b0;

	lock_wait_priority_queue DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	initial begin
		#50_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Apply one request to the shadow and return its result.
	function automatic queue_result_t predict_queue(input logic req, input logic [3:0] lock,
			input logic [7:0] prio, input logic kind, input logic [5:0] pid);
		queue_result_t r;
		entry_t w;
		int i, j, n;
		w = {prio, kind, pid};
		n = shadow_cnt[lock];
		r.st = ST_OK;
		r.pos = '0;
		if (req == REQ_INSERT) begin
			if (n >= QUEUE_DEPTH) begin
				r.st = ST_FULL;
				return r;
			end
			for (i = 0; i < n; i++)
				if (shadow_q[lock][i][14:7] < prio) break;
			for (j = n; j > i; j--) shadow_q[lock][j] = shadow_q[lock][j-1];
			shadow_q[lock][i] = w;
			shadow_cnt[lock] = n + 1;
			r.pos = i[3:0];
		end else begin
			for (i = 0; i < n; i++)
				if (shadow_q[lock][i] == w) break;
			if (i >= n) begin
				r.st = ST_NOMATCH;
				return r;
			end
			for (j = i; j + 1 < n; j++) shadow_q[lock][j] = shadow_q[lock][j+1];
			shadow_cnt[lock] = n - 1;
			r.pos = i[3:0];
		end
		return r;
	endfunction

	// Offer one request; hold it until the transfer, then predict it.
	task automatic send_request(input logic req, input logic [3:0] lock, input logic [7:0] prio,
			input logic kind, input logic [5:0] pid, input logic typed,
			input logic [1:0] st, input logic [3:0] pos);
		queue_result_t r;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {5'b0, pid, kind, prio, lock};
		do @(posedge clk); while (!s_tready);
		r = predict_queue(req, lock, prio, kind, pid);
		if (typed && (r.st !== st || r.pos !== pos))
			report_mismatch("table row", {r.st, r.pos}, {st, pos});
		if (typed) begin
			r.st = st;
			r.pos = pos;
		end
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int g;
		if ($urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			g = $urandom_range(1, 6);
			repeat (g) @(negedge clk);
		end
	endtask

	// Receiver: pattern stalls, plus one long hold-off.
	initial begin
		int phase, hold;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				m_tready <= 1'b0;
				for (hold = 0; hold < 300; hold++) @(negedge clk);
				long_hold = 1'b0;
			end
			phase++;
			if ((phase / 200) % 2 == 1) m_tready <= 1'b1;
			else m_tready <= ($urandom_range(0, 2) != 0) && (phase % 7 != 3);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		queue_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 0);
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[1:0] !== e.st) report_mismatch("status", m_tdata[1:0], e.st);
				if (m_tdata[5:2] !== e.pos) report_mismatch("position", m_tdata[5:2], e.pos);
				if (m_tdata[7:6] !== 2'b0) report_mismatch("fill", m_tdata[7:6], 0);
			end
		end
	end

	initial begin
		stim_row_t table_rows [$];
		stim_row_t row;
		int k, n, lk, idx, waited;
		entry_t w;
		for (k = 0; k < LOCK_COUNT; k++) shadow_cnt[k] = 0;
		// lock, prio, kind, pid; typed results only where obvious
		table_rows = '{
			'{REQ_REMOVE, 4'd0, 8'd0, 1'b0, 6'd0, 1'b1, ST_NOMATCH, 4'd0},
			'{REQ_INSERT, 4'd0, 8'd0, 1'b0, 6'd0, 1'b1, ST_OK, 4'd0},
			'{REQ_INSERT, 4'd0, 8'd255, 1'b1, 6'd63, 1'b1, ST_OK, 4'd0},
			'{REQ_INSERT, 4'd0, 8'd0, 1'b1, 6'd1, 1'b1, ST_OK, 4'd2},
			'{REQ_INSERT, 4'd0, 8'd128, 1'b0, 6'd42, 1'b0, ST_OK, 4'd0},
			'{REQ_REMOVE, 4'd0, 8'd0, 1'b1, 6'd1, 1'b0, ST_OK, 4'd0},
			'{REQ_REMOVE, 4'd0, 8'd255, 1'b1, 6'd63, 1'b1, ST_OK, 4'd0},
			'{REQ_REMOVE, 4'd0, 8'd255, 1'b1, 6'd63, 1'b1, ST_NOMATCH, 4'd0},
			'{REQ_REMOVE, 4'd0, 8'd128, 1'b1, 6'd42, 1'b1, ST_NOMATCH, 4'd0},
			'{REQ_INSERT, 4'd15, 8'd255, 1'b0, 6'd63, 1'b1, ST_OK, 4'd0},
			'{REQ_REMOVE, 4'd15, 8'd255, 1'b0, 6'd63, 1'b1, ST_OK, 4'd0}
		};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (table_rows[i]) begin
			row = table_rows[i];
			send_request(row.req, row.lock, row.prio, row.kind, row.pid, row.typed, row.st, row.pos);
		end
		// Fill lock 7 with equal priorities to reach full, then one more.
		for (k = 0; k < QUEUE_DEPTH; k++)
			send_request(REQ_INSERT, 4'd7, 8'd9, k[0], k[5:0], 1'b0, ST_OK, 4'd0);
		send_request(REQ_INSERT, 4'd7, 8'd200, 1'b0, 6'd5, 1'b1, ST_FULL, 4'd0);
		send_request(REQ_REMOVE, 4'd7, 8'd9, 1'b1, 6'd15, 1'b1, ST_OK, 4'd15);
		// Random traffic, at times kept on a few locks so queues fill and drain.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 400) long_hold = 1'b1;
			sender_gap();
			lk = (n % 500 < 250) ? $urandom_range(0, 3) : $urandom_range(0, 15);
			k = $urandom_range(0, 9);
			if (k < 5) begin
				send_request(REQ_INSERT, lk[3:0], (k == 0) ? 8'($urandom_range(0, 3) * 85)
					: 8'($urandom), 1'($urandom), 6'($urandom), 1'b0, ST_OK, 4'd0);
			end else if (k < 9 && shadow_cnt[lk] > 0) begin
				idx = $urandom_range(0, shadow_cnt[lk] - 1);
				w = shadow_q[lk][idx];
				send_request(REQ_REMOVE, lk[3:0], w[14:7], w[6], w[5:0], 1'b0, ST_OK, 4'd0);
			end else begin
				send_request(REQ_REMOVE, lk[3:0], 8'($urandom), 1'($urandom), 6'($urandom),
					1'b0, ST_OK, 4'd0);
			end
		end
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (20) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0 && !long_hold) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
src/lwpq_pkg.sv
src/lwpq_cell.sv
src/lock_wait_priority_queue.sv
bench/lock_wait_priority_queue_tb.sv
